[hw/rtl/assert_macros.svh]
// Assertion helpers for the segment intersection block.
// Every check is sampled on clk and is off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a property holds at every clock edge.
`define CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that the antecedent implies the consequent in the following cycle.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hw/rtl/segi_pkg.sv]
// ----------------------------------------------------------------------------
// segi_pkg
// Widths, register indexes and stage payload types shared by the modules, interfaces and bench.
// ----------------------------------------------------------------------------
`default_nettype none
package segi_pkg;
  localparam int COORD_W = 16;
  localparam int PFRAC   = 16;
  localparam int DIFF_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * DIFF_W;
  localparam int DET_W   = PROD_W + 2;
  localparam int BND_W   = 16;
  localparam int NUM_W   = DET_W + PFRAC;
  localparam int CMP_W   = NUM_W + 2;
  localparam int REM_W   = DET_W + 1;
  localparam int PT_W    = DIFF_W + PFRAC + 1;
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LOW_BOUND  = 2'd0,
    REG_HIGH_BOUND = 2'd1,
    REG_DET_TOL    = 2'd2
  } cfg_reg_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [DIFF_W-1:0]  diff_t;

  typedef struct packed {
    logic [BND_W-1:0] lo;
    logic [BND_W-1:0] hi;
    logic [BND_W-1:0] tol;
  } cfg_t;

  // Entry of the divider pipe and the point stages.
  typedef struct packed {
    logic             valid;
    logic             hit;
    logic             pen;
    logic [REM_W-1:0] rem;
    logic [DET_W-1:0] det;
    logic [PFRAC-1:0] q;
    coord_t           ax;
    coord_t           ay;
    diff_t            a1;
    diff_t            a2;
  } div_t;
endpackage
`default_nettype wire

[hw/rtl/segi_if.sv]
// ----------------------------------------------------------------------------
// segi interfaces
// Input, result and configuration channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface segi_in_if import segi_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   func;
  coord_t a_x;
  coord_t a_y;
  coord_t b_x;
  coord_t b_y;
  coord_t c_x;
  coord_t c_y;
  coord_t d_x;
  coord_t d_y;
  modport source (output valid, func, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y,
                  input ready);
  modport sink (input valid, func, a_x, a_y, b_x, b_y, c_x, c_y, d_x, d_y,
                output ready);
endinterface

interface segi_out_if import segi_pkg::*; ();
  logic   valid;
  logic   ready;
  logic   hit;
  coord_t point_x;
  coord_t point_y;
  modport source (output valid, hit, point_x, point_y, input ready);
  modport sink (input valid, hit, point_x, point_y, output ready);
endinterface

interface segi_cfg_if import segi_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] idx;
  logic [BND_W-1:0]     data;
  modport source (output valid, idx, data, input ready);
  modport sink (input valid, idx, data, output ready);
endinterface
`default_nettype wire

[hw/rtl/segi_calc.sv]
// ----------------------------------------------------------------------------
// segi_calc
// Differences, cross products, determinants and bound tests (five stages).
// ----------------------------------------------------------------------------
`default_nettype none
module segi_calc import segi_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   en,
  input  wire logic   in_valid,
  input  wire logic   func,
  input  wire coord_t ax_i, ay_i, bx_i, by_i, cx_i, cy_i, dx_i, dy_i,
  input  wire cfg_t   cfg,
  output div_t        out
);
  // stage 1: differences
  logic s1_v, s1_f;
  coord_t s1_ax, s1_ay;
  diff_t a1, a2, b1, b2, c1, c2, e1, e2, f1, f2, g1, g2;
  // stage 2: products
  logic s2_v, s2_f;
  coord_t s2_ax, s2_ay;
  diff_t s2_a1, s2_a2;
  logic signed [PROD_W-1:0] p_a1b2, p_a2b1, p_c1b2, p_b1c2, p_a1c2, p_c1a2;
  logic signed [PROD_W-1:0] p_a1e2, p_a2e1, p_f1g2, p_f2g1;
  // stage 3: sums, mode 0 verdict, sign normalization
  logic s3_v, s3_f, s3_h0;
  coord_t s3_ax, s3_ay;
  diff_t s3_a1, s3_a2;
  logic signed [DET_W-1:0] s3_det, s3_dx, s3_dy;
  // stage 4: bound products
  logic s4_v, s4_f, s4_h0;
  coord_t s4_ax, s4_ay;
  diff_t s4_a1, s4_a2;
  logic signed [DET_W-1:0] s4_det, s4_dx, s4_dy;
  logic [BND_W+DET_W-1:0] lo_det, hi_det;

  logic signed [DET_W-1:0] det_c, dx_c, dy_c, sabc_c, scdb_c;
  logic signed [CMP_W-1:0] nx, ny, lo_c, hi_c;
  logic h1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      out.valid <= 1'b0;
    end else if (en) begin
      s1_v <= in_valid;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      out.valid <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_f <= func;  s1_ax <= ax_i; s1_ay <= ay_i;
      a1 <= DIFF_W'(bx_i) - DIFF_W'(ax_i);  a2 <= DIFF_W'(by_i) - DIFF_W'(ay_i);
      b1 <= DIFF_W'(cx_i) - DIFF_W'(dx_i);  b2 <= DIFF_W'(cy_i) - DIFF_W'(dy_i);
      c1 <= DIFF_W'(cx_i) - DIFF_W'(ax_i);  c2 <= DIFF_W'(cy_i) - DIFF_W'(ay_i);
      e1 <= DIFF_W'(dx_i) - DIFF_W'(ax_i);  e2 <= DIFF_W'(dy_i) - DIFF_W'(ay_i);
      f1 <= DIFF_W'(dx_i) - DIFF_W'(cx_i);  f2 <= DIFF_W'(dy_i) - DIFF_W'(cy_i);
      g1 <= DIFF_W'(bx_i) - DIFF_W'(cx_i);  g2 <= DIFF_W'(by_i) - DIFF_W'(cy_i);

      s2_f <= s1_f; s2_ax <= s1_ax; s2_ay <= s1_ay; s2_a1 <= a1; s2_a2 <= a2;
      p_a1b2 <= a1 * b2;  p_a2b1 <= a2 * b1;
      p_c1b2 <= c1 * b2;  p_b1c2 <= b1 * c2;
      p_a1c2 <= a1 * c2;  p_c1a2 <= c1 * a2;
      p_a1e2 <= a1 * e2;  p_a2e1 <= a2 * e1;
      p_f1g2 <= f1 * g2;  p_f2g1 <= f2 * g1;

      s3_f <= s2_f; s3_ax <= s2_ax; s3_ay <= s2_ay; s3_a1 <= s2_a1; s3_a2 <= s2_a2;
      // C and D on opposite sides of AB, and A and B on opposite sides of CD
      s3_h0 <= (sabc_c != '0) && (scdb_c != '0) && (dy_c != '0) && (dx_c != '0) &&
               (dy_c[DET_W-1] != sabc_c[DET_W-1]) &&
               (dx_c[DET_W-1] == scdb_c[DET_W-1]);
      if (det_c[DET_W-1]) begin
        s3_det <= -det_c; s3_dx <= -dx_c; s3_dy <= -dy_c;
      end else begin
        s3_det <= det_c;  s3_dx <= dx_c;  s3_dy <= dy_c;
      end

      s4_f <= s3_f; s4_h0 <= s3_h0; s4_ax <= s3_ax; s4_ay <= s3_ay;
      s4_a1 <= s3_a1; s4_a2 <= s3_a2;
      s4_det <= s3_det; s4_dx <= s3_dx; s4_dy <= s3_dy;
      lo_det <= cfg.lo * $unsigned(s3_det);
      hi_det <= cfg.hi * $unsigned(s3_det);

      out.hit <= s4_f ? h1 : s4_h0;
      out.pen <= s4_f & h1;
      out.rem <= (s4_f & h1) ? REM_W'($unsigned(s4_dx)) : '0;
      out.det <= $unsigned(s4_det);
      out.q   <= '0;
      out.ax  <= s4_ax; out.ay <= s4_ay; out.a1 <= s4_a1; out.a2 <= s4_a2;
    end
  end

  always_comb begin
    det_c  = DET_W'(p_a1b2) - DET_W'(p_a2b1);
    dx_c   = DET_W'(p_c1b2) - DET_W'(p_b1c2);
    dy_c   = DET_W'(p_a1c2) - DET_W'(p_c1a2);
    sabc_c = DET_W'(p_a1e2) - DET_W'(p_a2e1);
    scdb_c = DET_W'(p_f1g2) - DET_W'(p_f2g1);
    nx   = CMP_W'(s4_dx) <<< PFRAC;
    ny   = CMP_W'(s4_dy) <<< PFRAC;
    lo_c = $signed({2'b00, lo_det});
    hi_c = $signed({2'b00, hi_det});
    h1 = ($unsigned(s4_det) > DET_W'(cfg.tol)) && (nx >= lo_c) && (nx <= hi_c) &&
         (ny >= lo_c) && (ny <= hi_c);
  end
endmodule
`default_nettype wire

[hw/rtl/segi_div.sv]
// ----------------------------------------------------------------------------
// segi_div
// Pipelined restoring divider, one quotient bit per stage: q = rem*2^P / det.
// ----------------------------------------------------------------------------
`default_nettype none
module segi_div import segi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire div_t in,
  output div_t      out
);
  div_t st [PFRAC+1];
  logic [REM_W-1:0] r2 [PFRAC];

  assign st[0] = in;
  assign out   = st[PFRAC];

  for (genvar k = 0; k < PFRAC; k++) begin : g_step
    assign r2[k] = {st[k].rem[REM_W-2:0], 1'b0};
    always_ff @(posedge clk) begin
      if (rst) begin
        st[k+1].valid <= 1'b0;
      end else if (en) begin
        st[k+1].valid <= st[k].valid;
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        st[k+1].hit <= st[k].hit;
        st[k+1].pen <= st[k].pen;
        st[k+1].det <= st[k].det;
        st[k+1].ax  <= st[k].ax;
        st[k+1].ay  <= st[k].ay;
        st[k+1].a1  <= st[k].a1;
        st[k+1].a2  <= st[k].a2;
        if (r2[k] >= REM_W'(st[k].det)) begin
          st[k+1].rem <= r2[k] - REM_W'(st[k].det);
          st[k+1].q   <= {st[k].q[PFRAC-2:0], 1'b1};
        end else begin
          st[k+1].rem <= r2[k];
          st[k+1].q   <= {st[k].q[PFRAC-2:0], 1'b0};
        end
      end
    end
  end
endmodule
`default_nettype wire

[hw/rtl/segi_point.sv]
// ----------------------------------------------------------------------------
// segi_point
// Point = A + floor((B-A)*q / 2^P): one multiply stage, one add stage.
// ----------------------------------------------------------------------------
`default_nettype none
module segi_point import segi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic en,
  input  wire div_t in,
  output logic      valid,
  output logic      hit,
  output coord_t    px,
  output coord_t    py
);
  logic m_v, m_hit, m_pen;
  coord_t m_ax, m_ay;
  logic signed [PT_W-1:0] mx, my, sx, sy;
  logic signed [DIFF_W:0] tq;

  assign tq = $signed({2'b00, in.q});
  assign sx = (mx >>> PFRAC) + PT_W'(m_ax);
  assign sy = (my >>> PFRAC) + PT_W'(m_ay);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_v   <= 1'b0;
      valid <= 1'b0;
    end else if (en) begin
      m_v   <= in.valid;
      valid <= m_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_hit <= in.hit; m_pen <= in.pen; m_ax <= in.ax; m_ay <= in.ay;
      mx <= PT_W'(in.a1 * tq);
      my <= PT_W'(in.a2 * tq);
      hit <= m_hit;
      px  <= m_pen ? sx[COORD_W-1:0] : '0;
      py  <= m_pen ? sy[COORD_W-1:0] : '0;
    end
  end
endmodule
`default_nettype wire

[hw/rtl/segment_intersection_top.sv]
// ----------------------------------------------------------------------------
// segment_intersection_top
// Segment crossing test and Cramer's rule intersection point, pipelined.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  in_ch   | in  | func, a_x..d_y (Q11.4)
//  out_ch  | out | hit, point_x, point_y
//  cfg_ch  | in  | idx, data (bounds and tolerance)
//
// The pipe has 5 arithmetic stages, 16 divider stages and 2 point stages;
// one transfer per cycle in and out while the output is not stalled.
// The divider pipe, one quotient bit per stage, sets the depth.
// The whole pipe advances whenever the output register is empty or taken,
// so a stall freezes every stage and nothing is lost or repeated.
// Synchronous reset clears valid bits and loads the register defaults.
`default_nettype none
`include "assert_macros.svh"
module segment_intersection_top import segi_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  segi_in_if.sink   in_ch,
  segi_out_if.source out_ch,
  segi_cfg_if.sink  cfg_ch
);
  cfg_t cfg;
  logic en;
  div_t calc_out, div_out;

  // global advance: output register free or being drained
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lo  <= BND_W'(655);
      cfg.hi  <= BND_W'(64880);
      cfg.tol <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.idx)
        REG_LOW_BOUND:  cfg.lo  <= cfg_ch.data;
        REG_HIGH_BOUND: cfg.hi  <= cfg_ch.data;
        REG_DET_TOL:    cfg.tol <= cfg_ch.data;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  segi_calc u_calc (
    .clk, .rst, .en,
    .in_valid(in_ch.valid), .func(in_ch.func),
    .ax_i(in_ch.a_x), .ay_i(in_ch.a_y), .bx_i(in_ch.b_x), .by_i(in_ch.b_y),
    .cx_i(in_ch.c_x), .cy_i(in_ch.c_y), .dx_i(in_ch.d_x), .dy_i(in_ch.d_y),
    .cfg, .out(calc_out)
  );

  segi_div u_div (.clk, .rst, .en, .in(calc_out), .out(div_out));

  segi_point u_point (
    .clk, .rst, .en, .in(div_out),
    .valid(out_ch.valid), .hit(out_ch.hit),
    .px(out_ch.point_x), .py(out_ch.point_y)
  );

  `CHK(a_zero_on_miss, !(out_ch.valid && !out_ch.hit) ||
       (out_ch.point_x == '0 && out_ch.point_y == '0), "point nonzero without hit")
  `CHK(a_inverted_bounds, !(out_ch.valid && cfg.lo > cfg.hi && calc_out.valid) ||
       !calc_out.pen, "hit with inverted bounds")
  `CHK_NEXT(a_fill, in_ch.valid && in_ch.ready, u_calc.s1_v, "accepted item dropped")
endmodule
`default_nettype wire

[verif/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for segment_intersection_top: random and directed
// segment pairs, both modes, several bound/tolerance settings, with random
// idling on both sides and a long output stall.
// ----------------------------------------------------------------------------
`default_nettype none
module tb import segi_pkg::*; ();

  typedef struct packed {
    logic   func;
    coord_t ax, ay, bx, by, cx, cy, dx, dy;
  } seg_pair_t;

  typedef struct packed {
    logic   hit;
    coord_t px, py;
  } isect_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  segi_in_if  in_ch ();
  segi_out_if out_ch ();
  segi_cfg_if cfg_ch ();

  segment_intersection_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // Predictor copy of the registers.
  longint lo_bound, hi_bound, tol;

  seg_pair_t pair_q[$];
  isect_t    isect_q[$];
  int        err_cnt = 0;
  int        src_idle_pct = 0;
  int        snk_idle_pct = 0;
  int        hold_cycles = 0;
  bit        hold_req = 1'b0;
  bit        src_pause = 1'b0;
  int        quiet_cnt = 0;

  function automatic int sgn(longint v);
    return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
  endfunction

  function automatic int side_of(longint px, longint py, longint qx, longint qy,
                                 longint rx, longint ry);
    return sgn((qx - px) * (ry - py) - (qy - py) * (rx - px));
  endfunction

  // Floor division by 2^16, toward minus infinity.
  function automatic longint floor_q16(longint v);
    return v >>> PFRAC;
  endfunction

  function automatic isect_t predict_isect(seg_pair_t p);
    isect_t r;
    longint ax, ay, bx, by, cx, cy, dx, dy;
    longint a1, a2, b1, b2, c1, c2, det, detx, dety, one, tq;
    ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
    cx = p.cx; cy = p.cy; dx = p.dx; dy = p.dy;
    r = '0;
    if (!p.func) begin
      if (side_of(ax, ay, bx, by, cx, cy) * side_of(ax, ay, bx, by, dx, dy) < 0 &&
          side_of(cx, cy, dx, dy, ax, ay) * side_of(cx, cy, dx, dy, bx, by) < 0)
        r.hit = 1'b1;
    end else begin
      a1 = bx - ax; a2 = by - ay;
      b1 = cx - dx; b2 = cy - dy;
      c1 = cx - ax; c2 = cy - ay;
      det  = a1 * b2 - a2 * b1;
      detx = c1 * b2 - b1 * c2;
      dety = a1 * c2 - c1 * a2;
      one  = 64'sd1 << PFRAC;
      if (det < 0) begin
        det = -det; detx = -detx; dety = -dety;
      end
      if (det > tol &&
          detx * one >= lo_bound * det && detx * one <= hi_bound * det &&
          dety * one >= lo_bound * det && dety * one <= hi_bound * det) begin
        tq = (detx * one) / det;
        r.hit = 1'b1;
        r.px = coord_t'(ax + floor_q16(a1 * tq));
        r.py = coord_t'(ay + floor_q16(a2 * tq));
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d want %0d", what, got, want);
    err_cnt++;
  endtask

  // Driver: offers the head of the pending queue; predicts on transfer.
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        isect_q.push_back(predict_isect(pair_q.pop_front()));
      end
      if (pair_q.size() > 0 && !src_pause &&
          $urandom_range(99) >= src_idle_pct) begin
        in_ch.valid <= 1'b1;
        {in_ch.func, in_ch.a_x, in_ch.a_y, in_ch.b_x, in_ch.b_y,
         in_ch.c_x, in_ch.c_y, in_ch.d_x, in_ch.d_y} <= pair_q[0];
      end else if (!(in_ch.valid && !in_ch.ready)) begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here.
  always @(posedge clk) begin
    if (hold_req && hold_cycles == 0) hold_cycles <= 200;
    else if (hold_cycles > 0) hold_cycles <= hold_cycles - 1;
  end

  // Monitor and receiver.
  always @(posedge clk) begin
    isect_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (isect_q.size() == 0) begin
          report_mismatch("unexpected result", 1, 0);
        end else begin
          want = isect_q.pop_front();
          if (out_ch.hit !== want.hit) report_mismatch("hit", out_ch.hit, want.hit);
          if (out_ch.point_x !== want.px) report_mismatch("point_x", out_ch.point_x, want.px);
          if (out_ch.point_y !== want.py) report_mismatch("point_y", out_ch.point_y, want.py);
        end
      end
      out_ch.ready <= (hold_cycles == 0 && !hold_req) &&
                      ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cnt <= 0;
    else
      quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt > 5000) begin
      $display("tb: errors");
      $finish;
    end
  end

  function automatic coord_t rnd_coord(int mode);
    case (mode)
      0: return coord_t'($urandom);
      1: return coord_t'($urandom_range(400) - 200);
      default: return coord_t'($urandom_range(4000) - 2000);
    endcase
  endfunction

  function automatic seg_pair_t rnd_pair();
    seg_pair_t p;
    int m;
    m = $urandom_range(2);
    p.func = $urandom_range(1);
    p.ax = rnd_coord(m); p.ay = rnd_coord(m);
    p.bx = rnd_coord(m); p.by = rnd_coord(m);
    p.cx = rnd_coord(m); p.cy = rnd_coord(m);
    p.dx = rnd_coord(m); p.dy = rnd_coord(m);
    // Some collinear/touching/parallel shapes.
    case ($urandom_range(9))
      0: begin p.cx = p.ax; p.cy = p.ay; end
      1: begin p.dx = p.cx + (p.bx - p.ax); p.dy = p.cy + (p.by - p.ay); end
      2: begin p.cx = p.bx; p.cy = p.by; p.dx = p.bx + (p.bx - p.ax); p.dy = p.by + (p.by - p.ay); end
      default: ;
    endcase
    return p;
  endfunction

  function automatic seg_pair_t mk(logic f, int ax, int ay, int bx, int by,
                                   int cx, int cy, int dx, int dy);
    seg_pair_t p;
    p = '{f, coord_t'(ax), coord_t'(ay), coord_t'(bx), coord_t'(by),
          coord_t'(cx), coord_t'(cy), coord_t'(dx), coord_t'(dy)};
    return p;
  endfunction

  task automatic wait_drained();
    while (pair_q.size() > 0 || isect_q.size() > 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t r, logic [BND_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.idx   <= r;
    cfg_ch.data  <= v;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    case (r)
      REG_LOW_BOUND:  lo_bound = v;
      REG_HIGH_BOUND: hi_bound = v;
      REG_DET_TOL:    tol = v;
      default: ;
    endcase
  endtask

  task automatic run_random(int n);
    repeat (n) pair_q.push_back(rnd_pair());
    wait_drained();
  endtask

  initial begin
    cfg_ch.valid = 1'b0;
    cfg_ch.idx = REG_LOW_BOUND;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.func = 1'b0;
    {in_ch.a_x, in_ch.a_y, in_ch.b_x, in_ch.b_y} = '0;
    {in_ch.c_x, in_ch.c_y, in_ch.d_x, in_ch.d_y} = '0;
    out_ch.ready = 1'b0;
    lo_bound = 655; hi_bound = 64880; tol = 0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: crossing, touching endpoint, collinear, parallel, extremes.
    for (int f = 0; f < 2; f++) begin
      pair_q.push_back(mk(f, 0, 0, 160, 160, 0, 160, 160, 0));
      pair_q.push_back(mk(f, 0, 0, 160, 160, 160, 160, 320, 0));
      pair_q.push_back(mk(f, 0, 0, 160, 0, 32, 0, 320, 0));
      pair_q.push_back(mk(f, 0, 0, 160, 0, 0, 16, 160, 16));
      pair_q.push_back(mk(f, -32768, -32768, 32767, 32767, -32768, 32767, 32767, -32768));
      pair_q.push_back(mk(f, 32767, -32768, -32768, 32767, 32767, 32767, -32768, -32768));
      pair_q.push_back(mk(f, -32768, 0, 32767, 0, 0, -32768, 0, 32767));
      pair_q.push_back(mk(f, -1, -1, 1, 1, -1, 1, 1, -1));
      pair_q.push_back(mk(f, 0, 0, 0, 0, 0, 0, 0, 0));
    end
    wait_drained();

    // Phase 1: sender idles lightly, receiver heavily.
    src_idle_pct = 16; snk_idle_pct = 81;
    run_random(350);

    // Back-pressure: receiver holds off while the sender keeps offering.
    // The request stays up until the hold counter has picked it up.
    hold_req = 1'b1;
    repeat (80) pair_q.push_back(rnd_pair());
    wait (hold_cycles > 0);
    hold_req = 1'b0;
    wait_drained();

    // Wide-open bounds, nonzero tolerance.
    write_reg(REG_LOW_BOUND, 16'd0);
    write_reg(REG_HIGH_BOUND, 16'hFFFF);
    write_reg(REG_DET_TOL, 16'd300);
    src_idle_pct = 81; snk_idle_pct = 16;
    run_random(350);

    // Sender pause until everything is back, then inverted bounds.
    src_pause = 1'b1;
    wait_drained();
    src_pause = 1'b0;
    write_reg(REG_LOW_BOUND, 16'hFFFF);
    write_reg(REG_HIGH_BOUND, 16'd0);
    write_reg(REG_DET_TOL, 16'hFFFF);
    src_idle_pct = 0; snk_idle_pct = 0;
    run_random(200);

    // Middle bounds, zero tolerance.
    write_reg(REG_LOW_BOUND, 16'd16384);
    write_reg(REG_HIGH_BOUND, 16'd49152);
    write_reg(REG_DET_TOL, 16'd0);
    run_random(250);

    write_reg(REG_LOW_BOUND, 16'd655);
    write_reg(REG_HIGH_BOUND, 16'd64880);
    src_idle_pct = 30; snk_idle_pct = 30;
    run_random(300);

    if (err_cnt == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

endmodule
`default_nettype wire
